// ===== design/sic_pkg.sv =====
// shared types and constants of the sparse image chunk decoder
`default_nettype none
package sic_pkg;

   localparam logic [31:0] SPARSE_MAGIC = 32'hED26_FF3A;
   localparam logic [15:0] SPARSE_MAJOR = 16'h0001;
   localparam logic [15:0] FILE_HDR_BYTES = 16'd28;
   localparam logic [15:0] CHUNK_HDR_BYTES = 16'd12;
   localparam logic [31:0] SKIP_CHUNK_BYTES = 32'd12;
   localparam logic [31:0] FILL_CHUNK_BYTES = 32'd16;

   localparam logic [15:0] CHUNK_RAW = 16'hCAC1;
   localparam logic [15:0] CHUNK_FILL = 16'hCAC2;
   localparam logic [15:0] CHUNK_SKIP = 16'hCAC3;
   localparam logic [15:0] CHUNK_CRC = 16'hCAC4;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_FILL = 2'd2;
   localparam logic [1:0] KIND_STATUS = 2'd3;

   localparam logic [2:0] STAT_OK = 3'd0;
   localparam logic [2:0] STAT_SHORT = 3'd1;
   localparam logic [2:0] STAT_HDR_SIZE = 3'd2;
   localparam logic [2:0] STAT_BLK_MULT = 3'd3;
   localparam logic [2:0] STAT_CHUNK_HDR = 3'd4;
   localparam logic [2:0] STAT_OVERFLOW = 3'd5;
   localparam logic [2:0] STAT_NOT_SPARSE = 3'd6;

   localparam logic [1:0] CSR_PART_START = 2'd0;
   localparam logic [1:0] CSR_PART_SIZE = 2'd1;
   localparam logic [1:0] CSR_BLK_SHIFT = 2'd2;

   localparam logic [4:0] BLK_SHIFT_RESET = 5'd9;

   typedef struct packed {
      logic [31:0] word;
      logic        last;
   } item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] block_address;
      logic [47:0] blk_count;
      logic [31:0] payload;
      logic [2:0]  status;
      logic        finished;
   } result_type;

   typedef struct packed {
      logic [47:0] part_start;
      logic [47:0] part_size;
      logic [4:0]  blk_shift;
   } cfg_type;

endpackage
`default_nettype wire

// ===== design/sic_in_reg.sv =====
// input register holding one image word
`default_nettype none
module sic_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire sic_pkg::item_type req_item,
   input  wire logic              take,
   output logic                   item_valid,
   output sic_pkg::item_type      item
);
   import sic_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule
`default_nettype wire

// ===== design/sic_core.sv =====
// header and chunk parser: state and result of one image word per cycle while the result register is free
`default_nettype none
module sic_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sic_pkg::cfg_type  cfg,
   input  wire logic              item_valid,
   input  wire sic_pkg::item_type item,
   input  wire logic              out_free,
   output logic                   take,
   output logic                   res_valid,
   output sic_pkg::result_type    res
);
   import sic_pkg::*;

   localparam logic [2:0] PH_HDR = 3'd0;
   localparam logic [2:0] PH_CHUNK = 3'd1;
   localparam logic [2:0] PH_RAW = 3'd2;
   localparam logic [2:0] PH_FILL = 3'd3;
   localparam logic [2:0] PH_CRC = 3'd4;
   localparam logic [2:0] PH_DRAIN = 3'd5;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  widx_ff, widx_in;
   logic [31:0] hdr_sizes_ff, hdr_sizes_in;
   logic [31:0] blk_bytes_ff, blk_bytes_in;
   logic [31:0] chunks_total_ff, chunks_total_in;
   logic [31:0] chunks_seen_ff, chunks_seen_in;
   logic [47:0] next_block_ff, next_block_in;
   logic [47:0] blocks_left_ff, blocks_left_in;
   logic [15:0] chunk_kind_ff, chunk_kind_in;
   logic [47:0] chunk_blocks_ff, chunk_blocks_in;
   logic [63:0] bytes_ff, bytes_in;
   logic [61:0] raw_left_ff, raw_left_in;

   logic [63:0] lba;
   logic [63:0] bytes_total;
   logic [31:0] blk_mask;
   logic [31:0] seen_next;
   logic        done;
   logic [47:0] done_blocks;
   logic        fin;
   logic [2:0]  fin_st;
   logic        have;
   result_type  res_c;

   assign take = item_valid && out_free;

   assign lba = bytes_ff >> cfg.blk_shift;
   assign bytes_total = bytes_ff + 64'd12;
   assign blk_mask = ~(32'hFFFF_FFFF << cfg.blk_shift);
   assign seen_next = chunks_seen_ff + 32'd1;

   always_comb begin
      phase_in = phase_ff;
      widx_in = widx_ff;
      hdr_sizes_in = hdr_sizes_ff;
      blk_bytes_in = blk_bytes_ff;
      chunks_total_in = chunks_total_ff;
      chunks_seen_in = chunks_seen_ff;
      next_block_in = next_block_ff;
      blocks_left_in = blocks_left_ff;
      chunk_kind_in = chunk_kind_ff;
      chunk_blocks_in = chunk_blocks_ff;
      bytes_in = bytes_ff;
      raw_left_in = raw_left_ff;
      done = 1'b0;
      done_blocks = chunk_blocks_ff;
      fin = 1'b0;
      fin_st = STAT_OK;
      have = 1'b0;
      res_c = '0;
      res_c.kind = KIND_STATUS;

      if (phase_ff == PH_DRAIN) begin
         // swallow words up to the end flag
         if (item.last) begin
            phase_in = PH_HDR;
            widx_in = '0;
         end
      end else begin
         unique case (phase_ff)
            PH_HDR: begin
               case (widx_ff)
                  3'd0: begin
                     if (item.word != SPARSE_MAGIC) begin
                        fin = 1'b1;
                        fin_st = STAT_NOT_SPARSE;
                     end
                  end
                  3'd1: begin
                     if (item.word[15:0] != SPARSE_MAJOR) begin
                        fin = 1'b1;
                        fin_st = STAT_NOT_SPARSE;
                     end
                  end
                  3'd2: hdr_sizes_in = item.word;
                  3'd3: blk_bytes_in = item.word;
                  3'd5: chunks_total_in = item.word;
                  3'd6: begin
                     if (hdr_sizes_ff[15:0] != FILE_HDR_BYTES) begin
                        fin = 1'b1;
                        fin_st = STAT_HDR_SIZE;
                     end else if ((blk_bytes_ff & blk_mask) != 32'd0) begin
                        fin = 1'b1;
                        fin_st = STAT_BLK_MULT;
                     end else if (hdr_sizes_ff[31:16] != CHUNK_HDR_BYTES) begin
                        fin = 1'b1;
                        fin_st = STAT_CHUNK_HDR;
                     end else begin
                        next_block_in = cfg.part_start;
                        blocks_left_in = cfg.part_size;
                        chunks_seen_in = '0;
                        phase_in = PH_CHUNK;
                        if (chunks_total_ff == 32'd0) begin
                           fin = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
               widx_in = (phase_in == PH_HDR) ? widx_ff + 3'd1 : 3'd0;
            end
            PH_CHUNK: begin
               if (widx_ff == 3'd0) begin
                  chunk_kind_in = item.word[15:0];
                  widx_in = 3'd1;
               end else if (widx_ff == 3'd1) begin
                  // byte length of the chunk, ready for the size checks
                  bytes_in = {32'd0, item.word} * {32'd0, blk_bytes_ff};
                  widx_in = 3'd2;
               end else begin
                  widx_in = 3'd0;
                  if (lba > {16'd0, blocks_left_ff}) begin
                     fin = 1'b1;
                     fin_st = STAT_OVERFLOW;
                  end else begin
                     chunk_blocks_in = lba[47:0];
                     done_blocks = lba[47:0];
                     case (chunk_kind_ff)
                        CHUNK_RAW: begin
                           if (bytes_total != {32'd0, item.word} || bytes_ff[1:0] != 2'd0) begin
                              fin = 1'b1;
                              fin_st = STAT_CHUNK_HDR;
                           end else begin
                              have = 1'b1;
                              res_c.kind = KIND_WRITE;
                              res_c.block_address = next_block_ff;
                              res_c.blk_count = lba[47:0];
                              raw_left_in = bytes_ff[63:2];
                              if (bytes_ff[63:2] == 62'd0) begin
                                 done = 1'b1;
                              end else begin
                                 phase_in = PH_RAW;
                              end
                           end
                        end
                        CHUNK_FILL: begin
                           if (item.word != FILL_CHUNK_BYTES) begin
                              fin = 1'b1;
                              fin_st = STAT_CHUNK_HDR;
                           end else begin
                              phase_in = PH_FILL;
                           end
                        end
                        CHUNK_SKIP: begin
                           if (item.word != SKIP_CHUNK_BYTES) begin
                              fin = 1'b1;
                              fin_st = STAT_CHUNK_HDR;
                           end else begin
                              done = 1'b1;
                           end
                        end
                        CHUNK_CRC: begin
                           if (item.word != FILL_CHUNK_BYTES) begin
                              fin = 1'b1;
                              fin_st = STAT_CHUNK_HDR;
                           end else begin
                              phase_in = PH_CRC;
                           end
                        end
                        default: begin
                           fin = 1'b1;
                           fin_st = STAT_CHUNK_HDR;
                        end
                     endcase
                  end
               end
            end
            PH_RAW: begin
               have = 1'b1;
               res_c.kind = KIND_DATA;
               res_c.payload = item.word;
               raw_left_in = raw_left_ff - 62'd1;
               if (raw_left_ff == 62'd1) begin
                  done = 1'b1;
               end
            end
            PH_FILL: begin
               have = 1'b1;
               res_c.kind = KIND_FILL;
               res_c.block_address = next_block_ff;
               res_c.blk_count = chunk_blocks_ff;
               res_c.payload = item.word;
               done = 1'b1;
            end
            default: begin
               // crc word is skipped
               done = 1'b1;
            end
         endcase

         if (done) begin
            next_block_in = next_block_ff + done_blocks;
            blocks_left_in = blocks_left_ff - done_blocks;
            chunks_seen_in = seen_next;
            phase_in = PH_CHUNK;
            widx_in = 3'd0;
            if (seen_next == chunks_total_ff) begin
               fin = 1'b1;
            end
         end

         if (item.last && !fin) begin
            fin = 1'b1;
            fin_st = STAT_SHORT;
         end

         if (fin) begin
            phase_in = item.last ? PH_HDR : PH_DRAIN;
            widx_in = 3'd0;
            res_c.status = fin_st;
            res_c.finished = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         widx_ff <= '0;
         hdr_sizes_ff <= '0;
         blk_bytes_ff <= '0;
         chunks_total_ff <= '0;
         chunks_seen_ff <= '0;
         next_block_ff <= '0;
         blocks_left_ff <= '0;
         chunk_kind_ff <= '0;
         chunk_blocks_ff <= '0;
         bytes_ff <= '0;
         raw_left_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         widx_ff <= widx_in;
         hdr_sizes_ff <= hdr_sizes_in;
         blk_bytes_ff <= blk_bytes_in;
         chunks_total_ff <= chunks_total_in;
         chunks_seen_ff <= chunks_seen_in;
         next_block_ff <= next_block_in;
         blocks_left_ff <= blocks_left_in;
         chunk_kind_ff <= chunk_kind_in;
         chunk_blocks_ff <= chunk_blocks_in;
         bytes_ff <= bytes_in;
         raw_left_ff <= raw_left_in;
      end
   end

   assign res_valid = take && (fin || have);
   assign res = res_c;

`ifndef SYNTHESIS
   a_end_flag_closes: assert property (@(posedge clock) disable iff (reset)
      (take && item.last) |=> (phase_ff == PH_HDR))
      else $error("end flag did not return parser to header phase");

   a_finish_drains: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.finished && !item.last) |=> (phase_ff == PH_DRAIN))
      else $error("finished result without end flag did not drain");

   a_data_from_raw: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.kind == KIND_DATA) |-> (phase_ff == PH_RAW))
      else $error("data word emitted outside a raw chunk");

   a_widx_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_HDR && phase_ff != PH_CHUNK) |-> (widx_ff == 3'd0))
      else $error("word index left nonzero in a body phase");
`endif

endmodule
`default_nettype wire

// ===== design/sic_out_reg.sv =====
// result register on the response side
`default_nettype none
module sic_out_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire sic_pkg::result_type res,
   output logic                     out_free,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output sic_pkg::result_type      rsp_res
);
   import sic_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign out_free = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_res = res_ff;

endmodule
`default_nettype wire

// ===== design/sparse_image_chunk_decoder.sv =====
// Sparse image chunk decoder: image words in, write/fill commands and data out.
//
// req_*: one 32-bit little-endian image word per request, req_tlast on the
//   last word of the image.
// rsp_*: results; rsp_tuser is the kind (data word, write command, fill
//   command, status only), rsp_tlast marks the one result per image that
//   carries the final status.
// csr_*: register writes (partition start, partition size, device block
//   shift); always ready; write only while no image is in flight, the block does not check.
// Throughput is one word per cycle while rsp_* is not stalled: each word
// passes the input register, the parser logic and the result register
// before its result is presented on rsp_*. The chunk byte length is formed
// by one 32x32 multiply when the chunk size word arrives and checked on
// the next word.
// When rsp_tready is low the result register holds and the input register
// still takes one more request; then req_tready drops.
// Reset empties both registers and sets the parser to wait for a header.
`default_nettype none
module sparse_image_chunk_decoder (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [31:0]   req_tdata,  // image_word
   input  wire logic          req_tlast,  // end_of_image
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [135:0]       rsp_tdata,  // block_address, blk_count, payload, status, zeros
   output logic [1:0]         rsp_tuser,  // kind
   output logic               rsp_tlast,  // finished
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [47:0]   csr_data
);
   import sic_pkg::*;

   logic [47:0] part_start_ff;
   logic [47:0] part_size_ff;
   logic [4:0]  blk_shift_ff;
   cfg_type     cfg;
   item_type    req_item;
   item_type    item;
   logic        item_valid;
   logic        take;
   logic        out_free;
   logic        res_valid;
   result_type  res;
   result_type  rsp_res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         part_start_ff <= '0;
         part_size_ff <= '0;
         blk_shift_ff <= BLK_SHIFT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PART_START: part_start_ff <= csr_data;
            CSR_PART_SIZE: part_size_ff <= csr_data;
            CSR_BLK_SHIFT: blk_shift_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   assign cfg.part_start = part_start_ff;
   assign cfg.part_size = part_size_ff;
   assign cfg.blk_shift = blk_shift_ff;

   assign req_item.word = req_tdata;
   assign req_item.last = req_tlast;

   sic_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   sic_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .take       (take),
      .res_valid  (res_valid),
      .res        (res)
   );

   sic_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (res_valid),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = {5'd0, rsp_res.status, rsp_res.payload,
                       rsp_res.blk_count, rsp_res.block_address};
   assign rsp_tuser = rsp_res.kind;
   assign rsp_tlast = rsp_res.finished;

endmodule
`default_nettype wire

// ===== tb/image_decode_checker.sv =====
// checker for the sparse image decoder: mirrors its parsing and compares every response
`timescale 1ns / 100ps
module image_decode_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [31:0]  req_tdata,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [135:0] rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [47:0]  csr_data,
   output int           fail_count,
   output int           pending
);
   import sic_pkg::*;

   typedef enum logic [2:0] {
      AWAIT_HEADER, AWAIT_CHUNK, RAW_DATA, FILL_PATTERN, CRC_WORD, DRAIN
   } parse_phase_type;

   logic [47:0]     part_start, part_size;
   logic [4:0]      blk_shift;
   parse_phase_type phase;
   logic [2:0]      word_idx;
   logic [31:0]     img_blk_bytes, chunks_total, chunks_seen, chunk_img_blocks, hdr_sizes;
   logic [47:0]     next_block, blocks_left, chunk_blocks;
   logic [15:0]     chunk_type;
   logic [61:0]     raw_left;
   result_type      expected_q[$];
   int              mismatches;

   // advance past a completed chunk; true once the last chunk of the image is done
   function automatic logic close_chunk();
      next_block = next_block + chunk_blocks;
      blocks_left = blocks_left - chunk_blocks;
      chunks_seen = chunks_seen + 32'd1;
      phase = AWAIT_CHUNK;
      word_idx = '0;
      return chunks_seen == chunks_total;
   endfunction

   function automatic void decode_word(input logic [31:0] w, input logic last);
      logic        have, done;
      logic [2:0]  st;
      result_type  r;
      logic [63:0] bytes, lba;
      have = 1'b0;
      done = 1'b0;
      st = STAT_OK;
      r = '0;
      r.kind = KIND_STATUS;
      // after the final status, words are swallowed up to the end flag
      if (phase == DRAIN) begin
         if (last) begin
            phase = AWAIT_HEADER;
            word_idx = '0;
         end
         return;
      end
      case (phase)
         AWAIT_HEADER: begin
            case (word_idx)
               3'd0: if (w != SPARSE_MAGIC) begin
                  done = 1'b1;
                  st = STAT_NOT_SPARSE;
               end
               3'd1: if (w[15:0] != SPARSE_MAJOR) begin
                  done = 1'b1;
                  st = STAT_NOT_SPARSE;
               end
               3'd2: hdr_sizes = w;
               3'd3: img_blk_bytes = w;
               3'd5: chunks_total = w;
               3'd6: begin
                  done = 1'b1;
                  if (hdr_sizes[15:0] != FILE_HDR_BYTES) st = STAT_HDR_SIZE;
                  else if ((img_blk_bytes & ((32'd1 << blk_shift) - 32'd1)) != 0)
                     st = STAT_BLK_MULT;
                  else if (hdr_sizes[31:16] != CHUNK_HDR_BYTES) st = STAT_CHUNK_HDR;
                  else begin
                     next_block = part_start;
                     blocks_left = part_size;
                     chunks_seen = '0;
                     phase = AWAIT_CHUNK;
                     done = (chunks_total == 0);
                  end
               end
               default: ;
            endcase
            word_idx = word_idx + 3'd1;
            if (phase != AWAIT_HEADER) word_idx = '0;
         end
         AWAIT_CHUNK: begin
            if (word_idx == 3'd0) begin
               chunk_type = w[15:0];
               word_idx = 3'd1;
            end else if (word_idx == 3'd1) begin
               chunk_img_blocks = w;
               word_idx = 3'd2;
            end else begin
               bytes = {32'd0, chunk_img_blocks} * {32'd0, img_blk_bytes};
               lba = bytes >> blk_shift;
               word_idx = '0;
               if (lba > {16'd0, blocks_left}) begin
                  done = 1'b1;
                  st = STAT_OVERFLOW;
               end else begin
                  chunk_blocks = lba[47:0];
                  case (chunk_type)
                     CHUNK_RAW: begin
                        if (bytes + 64'd12 != {32'd0, w} || bytes[1:0] != 2'd0) begin
                           done = 1'b1;
                           st = STAT_CHUNK_HDR;
                        end else begin
                           have = 1'b1;
                           r.kind = KIND_WRITE;
                           r.block_address = next_block;
                           r.blk_count = lba[47:0];
                           raw_left = bytes[63:2];
                           if (raw_left == 0) done = close_chunk();
                           else phase = RAW_DATA;
                        end
                     end
                     CHUNK_FILL: begin
                        if (w != FILL_CHUNK_BYTES) begin
                           done = 1'b1;
                           st = STAT_CHUNK_HDR;
                        end else phase = FILL_PATTERN;
                     end
                     CHUNK_SKIP: begin
                        if (w != SKIP_CHUNK_BYTES) begin
                           done = 1'b1;
                           st = STAT_CHUNK_HDR;
                        end else done = close_chunk();
                     end
                     CHUNK_CRC: begin
                        if (w != FILL_CHUNK_BYTES) begin
                           done = 1'b1;
                           st = STAT_CHUNK_HDR;
                        end else phase = CRC_WORD;
                     end
                     default: begin
                        done = 1'b1;
                        st = STAT_CHUNK_HDR;
                     end
                  endcase
               end
            end
         end
         RAW_DATA: begin
            have = 1'b1;
            r.kind = KIND_DATA;
            r.payload = w;
            raw_left = raw_left - 62'd1;
            if (raw_left == 0) done = close_chunk();
         end
         FILL_PATTERN: begin
            have = 1'b1;
            r.kind = KIND_FILL;
            r.block_address = next_block;
            r.blk_count = chunk_blocks;
            r.payload = w;
            done = close_chunk();
         end
         default: done = close_chunk();
      endcase
      // image ended before its last chunk completed
      if (last && !done) begin
         done = 1'b1;
         st = STAT_SHORT;
      end
      if (done) begin
         phase = last ? AWAIT_HEADER : DRAIN;
         word_idx = '0;
      end
      if (done || have) begin
         r.status = done ? st : STAT_OK;
         r.finished = done;
         expected_q.push_back(r);
      end
   endfunction

   always @(posedge clock) begin : monitor
      result_type got, want;
      if (reset) begin
         part_start = '0;
         part_size = '0;
         blk_shift = BLK_SHIFT_RESET;
         phase = AWAIT_HEADER;
         word_idx = '0;
         img_blk_bytes = '0;
         chunks_total = '0;
         chunks_seen = '0;
         chunk_img_blocks = '0;
         hdr_sizes = '0;
         next_block = '0;
         blocks_left = '0;
         chunk_blocks = '0;
         chunk_type = '0;
         raw_left = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PART_START: part_start = csr_data;
               CSR_PART_SIZE: part_size = csr_data;
               CSR_BLK_SHIFT: blk_shift = csr_data[4:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) decode_word(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.block_address = rsp_tdata[47:0];
            got.blk_count = rsp_tdata[95:48];
            got.payload = rsp_tdata[127:96];
            got.status = rsp_tdata[130:128];
            got.finished = rsp_tlast;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t unexpected: kind %0d addr %h cnt %h data %h st %0d fin %b",
                           $realtime, got.kind, got.block_address, got.blk_count,
                           got.payload, got.status, got.finished);
            end else begin
               want = expected_q.pop_front();
               if (got.kind !== want.kind || got.block_address !== want.block_address ||
                   got.blk_count !== want.blk_count || got.payload !== want.payload ||
                   got.status !== want.status || got.finished !== want.finished) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t expected: kind %0d addr %h cnt %h data %h st %0d fin %b",
                              $realtime, want.kind, want.block_address, want.blk_count,
                              want.payload, want.status, want.finished);
                     $display("%0t actual:   kind %0d addr %h cnt %h data %h st %0d fin %b",
                              $realtime, got.kind, got.block_address, got.blk_count,
                              got.payload, got.status, got.finished);
                  end
               end
            end
         end
      end
      fail_count <= mismatches;
      pending <= expected_q.size();
   end

endmodule

// ===== tb/sparse_image_chunk_decoder_tb.sv =====
// testbench top: drives sparse images and register writes into the decoder and gives the verdict
`timescale 1ns / 100ps
module sparse_image_chunk_decoder_tb;
   import sic_pkg::*;

   typedef enum {
      FLAW_NONE, FLAW_MAGIC, FLAW_MAJOR, FLAW_FILE_HDR, FLAW_CHUNK_HDR, FLAW_BLK_MULT,
      FLAW_CHUNK_TYPE, FLAW_CHUNK_SIZE, FLAW_TRUNCATE, FLAW_EXTRA, FLAW_NOISE
   } image_flaw_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic [31:0]  req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tready = 1'b0;
   logic         csr_valid = 1'b0;
   logic [1:0]   csr_index = CSR_PART_START;
   logic [47:0]  csr_data = '0;
   logic         req_tready, rsp_tvalid, rsp_tlast, csr_ready;
   logic [135:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   int           fail_count, pending;

   int           send_idle_pct = 28;
   int           stall_pct = 72;
   int           words_sent;
   logic [4:0]   cur_shift = BLK_SHIFT_RESET;
   logic [31:0]  image_q[$];

   sparse_image_chunk_decoder dut (.*);
   image_decode_checker decode_check (.*);

   always #6 clock = ~clock;

   always @(posedge clock) rsp_tready <= ($urandom_range(0, 99) >= stall_pct);

   initial begin
      #5_000_000;
      $display("sparse_image_chunk_decoder test failed");
      $finish;
   end

   task automatic write_reg(input logic [1:0] index, input logic [47:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_config(input logic [47:0] start, input logic [47:0] size,
                             input logic [4:0] shift);
      write_reg(CSR_PART_START, start);
      write_reg(CSR_PART_SIZE, size);
      write_reg(CSR_BLK_SHIFT, {43'd0, shift});
      csr_valid <= 1'b0;
      cur_shift = shift;
   endtask

   // let outstanding responses drain and the pipeline empty before touching registers
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_header(input logic [31:0] blk_bytes, input logic [31:0] n_chunks);
      image_q.push_back(SPARSE_MAGIC);
      image_q.push_back({16'($urandom), SPARSE_MAJOR});
      image_q.push_back({CHUNK_HDR_BYTES, FILE_HDR_BYTES});
      image_q.push_back(blk_bytes);
      image_q.push_back($urandom);
      image_q.push_back(n_chunks);
      image_q.push_back($urandom);
   endtask

   task automatic add_chunk(input logic [15:0] ck, input logic [31:0] blocks,
                            input logic [31:0] blk_bytes, input logic bad_size);
      logic [31:0] total;
      int          n_data;
      case (ck)
         CHUNK_RAW: begin
            total = blocks * blk_bytes + 32'd12;
            n_data = (blocks * blk_bytes) / 4;
         end
         CHUNK_SKIP: begin
            total = SKIP_CHUNK_BYTES;
            n_data = 0;
         end
         default: begin
            total = FILL_CHUNK_BYTES;
            n_data = 1;
         end
      endcase
      if (bad_size) total = total ^ 32'($urandom_range(1, 15));
      image_q.push_back({16'($urandom), ck});
      image_q.push_back(blocks);
      image_q.push_back(total);
      repeat (n_data) image_q.push_back($urandom);
   endtask

   task automatic random_image();
      image_flaw_type flaw;
      logic [31:0]    unit, blk_bytes, blocks, w;
      logic [15:0]    ck;
      int             r, n, bad_at;
      r = $urandom_range(0, 99);
      if (r < 50) flaw = FLAW_NONE;
      else if (r < 55) flaw = FLAW_MAGIC;
      else if (r < 60) flaw = FLAW_MAJOR;
      else if (r < 65) flaw = FLAW_FILE_HDR;
      else if (r < 70) flaw = FLAW_CHUNK_HDR;
      else if (r < 75) flaw = FLAW_BLK_MULT;
      else if (r < 80) flaw = FLAW_CHUNK_TYPE;
      else if (r < 85) flaw = FLAW_CHUNK_SIZE;
      else if (r < 92) flaw = FLAW_TRUNCATE;
      else if (r < 97) flaw = FLAW_EXTRA;
      else flaw = FLAW_NOISE;

      unit = 32'd1 << cur_shift;
      if ($urandom_range(0, 9) == 0) blk_bytes = $urandom & ~(unit - 32'd1);
      else blk_bytes = unit << $urandom_range(0, 3);
      if (flaw == FLAW_BLK_MULT) blk_bytes = blk_bytes | $urandom_range(1, unit - 1);
      n = $urandom_range(0, 4);
      if ((flaw == FLAW_CHUNK_TYPE || flaw == FLAW_CHUNK_SIZE) && n == 0) n = 1;
      bad_at = (n > 0) ? $urandom_range(0, n - 1) : 0;

      add_header(blk_bytes, 32'(n));
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 3))
            0: ck = CHUNK_RAW;
            1: ck = CHUNK_FILL;
            2: ck = CHUNK_SKIP;
            default: ck = CHUNK_CRC;
         endcase
         // raw chunks stay short so data words do not dominate the run
         if (ck == CHUNK_RAW)
            blocks = (blk_bytes == 0) ? $urandom : $urandom_range(0, 96 / blk_bytes);
         else
            blocks = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 64);
         if (flaw == FLAW_CHUNK_TYPE && i == bad_at) begin
            ck = 16'($urandom);
            if (ck >= CHUNK_RAW && ck <= CHUNK_CRC) ck = CHUNK_RAW - 16'd1;
         end
         add_chunk(ck, blocks, blk_bytes, flaw == FLAW_CHUNK_SIZE && i == bad_at);
      end

      case (flaw)
         FLAW_MAGIC: begin
            w = image_q[0];
            image_q[0] = w ^ (32'd1 << $urandom_range(0, 31));
         end
         FLAW_MAJOR: begin
            w = image_q[1];
            image_q[1] = w ^ 32'($urandom_range(1, 16'hFFFF));
         end
         FLAW_FILE_HDR: begin
            w = image_q[2];
            image_q[2] = w ^ 32'($urandom_range(1, 16'hFFFF));
         end
         FLAW_CHUNK_HDR: begin
            w = image_q[2];
            image_q[2] = w ^ (32'($urandom_range(1, 16'hFFFF)) << 16);
         end
         FLAW_TRUNCATE: repeat ($urandom_range(1, image_q.size() - 1)) void'(image_q.pop_back());
         FLAW_EXTRA: repeat ($urandom_range(1, 4)) image_q.push_back($urandom);
         FLAW_NOISE: begin
            image_q.delete();
            repeat ($urandom_range(1, 6)) image_q.push_back($urandom);
         end
         default: ;
      endcase
   endtask

   // send the queued image, end flag on its final word
   task automatic send_image();
      for (int i = 0; i < image_q.size(); i++) begin
         while ($urandom_range(0, 99) < send_idle_pct) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata <= image_q[i];
         req_tlast <= (i == image_q.size() - 1);
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      words_sent += image_q.size();
      image_q.delete();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_config(48'hFFFF_FFFF_FFF0, '1, 5'd2);

      // every chunk type in one image, block addresses just below the top of the range
      add_header(32'd4, 32'd4);
      add_chunk(CHUNK_RAW, 32'd2, 32'd4, 1'b0);
      add_chunk(CHUNK_FILL, 32'd3, 32'd4, 1'b0);
      add_chunk(CHUNK_SKIP, 32'd5, 32'd4, 1'b0);
      add_chunk(CHUNK_CRC, 32'd0, 32'd4, 1'b0);
      send_image();
      image_q.push_back('1);
      send_image();
      image_q.push_back('0);
      send_image();

      for (int seg = 0; seg < 6; seg++) begin
         wait_idle();
         case (seg)
            0: set_config('0, '1, 5'd2);
            1: set_config(48'({$urandom, $urandom}), 48'($urandom_range(0, 3000)),
                          5'($urandom_range(2, 8)));
            2: set_config('1, '1, 5'd16);
            3: set_config(48'({$urandom, $urandom}), '0, 5'd3);
            4: set_config(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                          5'($urandom_range(2, 16)));
            default: set_config('0, '1, 5'd4);
         endcase
         send_idle_pct = (seg < 2) ? 28 : (seg < 4) ? 72 : 0;
         stall_pct = (seg < 2) ? 72 : (seg < 4) ? 28 : 0;
         words_sent = 0;
         while (words_sent < 310) begin
            random_image();
            send_image();
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("sparse_image_chunk_decoder test passed");
      end else begin
         $display("sparse_image_chunk_decoder test failed");
      end
      $finish;
   end

endmodule
